// ----- src/sfcrc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcrc_pkg: shared types and constants for the scope frame encoder
// Frame geometry, CRC-16/MODBUS constants, the byte-update function and the
// byte request struct passed from the frame source to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcrc_pkg;

  // frame geometry
  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned NUM_CHAN   = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned FRAME_W    = CHAN_W * NUM_CHAN;
  localparam int unsigned DATA_IDX_W = 3;

  localparam logic [POS_W-1:0] POS_FIRST   = 4'd0;
  localparam logic [POS_W-1:0] POS_DATA_N  = 4'd8;
  localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd8;
  localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd9;
  localparam logic [POS_W-1:0] POS_LAST    = 4'd9;

  // crc-16/modbus, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef logic [15:0]        crc_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [POS_W-1:0]   pos_t;

  // one byte request from the frame source
  typedef struct packed {
    logic  valid;
    byte_t data;
    pos_t  pos;
  } byte_req_t;

  // fold one byte into the crc, lsb first
  function automatic crc_t crc_byte(input crc_t crc_in, input byte_t data);
    crc_t c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/sfcrc_frame_src.sv -----
// ----------------------------------------------------------------------------
// sfcrc_frame_src: input register and byte sequencer
// Captures the four channel values and steps through frame positions 0..9,
// offering one byte request per position to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcrc_frame_src
  import sfcrc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [CHAN_W-1:0]   in_channel_0,
  input  wire logic [CHAN_W-1:0]   in_channel_1,
  input  wire logic [CHAN_W-1:0]   in_channel_2,
  input  wire logic [CHAN_W-1:0]   in_channel_3,
  output      byte_req_t           req,
  input  wire logic                take
);

  logic [FRAME_W-1:0] frame_r, frame_nxt;
  pos_t               pos_r, pos_nxt;
  logic               active_r, active_nxt;
  logic               load;
  logic               frame_done;

  // current frame finishes when its last byte is taken
  assign frame_done = take && (pos_r == POS_LAST);
  assign in_ready   = !active_r || frame_done;
  assign load       = in_valid && in_ready;

  // byte request for the current position
  always_comb begin
    req.valid = active_r;
    req.pos   = pos_r;
    req.data  = frame_r[pos_r[DATA_IDX_W-1:0]*BYTE_W +: BYTE_W];
  end

  // next frame, position and active flag
  always_comb begin
    frame_nxt  = frame_r;
    pos_nxt    = pos_r;
    active_nxt = active_r;
    if (take) begin
      pos_nxt = pos_r + 4'd1;
      if (frame_done) begin
        active_nxt = 1'b0;
      end
    end
    if (load) begin
      frame_nxt  = {in_channel_3, in_channel_2, in_channel_1, in_channel_0};
      pos_nxt    = POS_FIRST;
      active_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= POS_FIRST;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // frame payload
  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pos_r <= POS_LAST))
    else $error("frame position beyond last byte");

  a_load_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (load && active_r) |-> (take && (pos_r == POS_LAST)))
    else $error("new request loaded over an unfinished frame");

  a_take_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> active_r)
    else $error("byte taken with no frame loaded");

  a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (active_r && (pos_r == POS_FIRST)))
    else $error("loaded frame does not start at position zero");
`endif

endmodule

`default_nettype wire

// ----- src/sfcrc_out_stage.sv -----
// ----------------------------------------------------------------------------
// sfcrc_out_stage: crc accumulator and result register
// Folds each data byte into the crc as it is issued, appends the crc bytes
// and holds the current result byte until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcrc_out_stage
  import sfcrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire byte_req_t  req,
  output      logic       take,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      byte_t      out_frame_byte,
  output      pos_t       out_byte_position,
  output      logic       out_last_byte
);

  crc_t  crc_r, crc_nxt, crc_base;
  logic  out_valid_r, out_valid_nxt;
  byte_t out_byte_r;
  pos_t  out_pos_r;
  logic  out_last_r;
  byte_t sel_byte;
  logic  is_data;

  // result register free or draining this cycle
  assign take    = req.valid && (!out_valid_r || out_ready);
  assign is_data = (req.pos < POS_DATA_N);

  // crc restarts on the first byte of a frame
  assign crc_base = (req.pos == POS_FIRST) ? CRC_INIT : crc_r;

  always_comb begin
    crc_nxt = crc_r;
    if (take && is_data) begin
      crc_nxt = crc_byte(crc_base, req.data);
    end
  end

  // byte select: data, then crc low, then crc high
  always_comb begin
    if (is_data) begin
      sel_byte = req.data;
    end else if (req.pos == POS_CRC_LO) begin
      sel_byte = crc_r[7:0];
    end else begin
      sel_byte = crc_r[15:8];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (take) begin
      out_byte_r <= sel_byte;
      out_pos_r  <= req.pos;
      out_last_r <= (req.pos == POS_CRC_HI);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = out_byte_r;
  assign out_byte_position = out_pos_r;
  assign out_last_byte     = out_last_r;

`ifndef NO_ASSERTIONS
  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_pos_r == POS_LAST))
    else $error("last flag on a byte other than the crc high byte");

  a_last_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_pos_r == POS_LAST)) |-> out_last_r)
    else $error("crc high byte not flagged as last");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid_r)
    else $error("issued byte did not reach the result register");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !take)
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- src/scope_frame_crc16_encoder_core.sv -----
// ----------------------------------------------------------------------------
// scope_frame_crc16_encoder_core: oscilloscope frame encoder with crc-16
// Turns one request of four 16-bit channel values into a ten-byte frame:
// the channels low byte first, then a crc-16/modbus over those eight bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries the four channel values; the
//   result channel (out_valid/out_ready) carries one frame byte per request
//   with its position 0..9, and out_last_byte marks the crc high byte.
//   Byte 0 is captured into the frame register, then the result register.
//   Throughput: one byte per cycle while out_ready stays high; the byte
//   sequencer and the single result register set that rate. The next
//   input is taken in the same cycle the crc high byte is issued, so frames
//   follow without gaps.
//   The crc is built as the data bytes go out, one per cycle unless stalled.
//   Stall: while out_ready is low the result register holds its byte, the
//   sequencer waits and in_ready stays low until the frame is finished.
//   Reset (rst_n low, synchronous): the frame in progress is dropped and
//   both channels come up empty; no clearing cycles are needed.
// ----------------------------------------------------------------------------
`default_nettype none

module scope_frame_crc16_encoder_core
  import sfcrc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [CHAN_W-1:0]  in_channel_0,
  input  wire logic [CHAN_W-1:0]  in_channel_1,
  input  wire logic [CHAN_W-1:0]  in_channel_2,
  input  wire logic [CHAN_W-1:0]  in_channel_3,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [BYTE_W-1:0]  out_frame_byte,
  output      logic [POS_W-1:0]   out_byte_position,
  output      logic               out_last_byte
);

  byte_req_t req;
  logic      take;

  // input register and byte sequencer
  sfcrc_frame_src u_frame_src (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_channel_0 (in_channel_0),
    .in_channel_1 (in_channel_1),
    .in_channel_2 (in_channel_2),
    .in_channel_3 (in_channel_3),
    .req          (req),
    .take         (take)
  );

  // crc accumulator and result register
  sfcrc_out_stage u_out_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .req               (req),
    .take              (take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_last_byte     (out_last_byte)
  );

endmodule

`default_nettype wire
